>>> rtl/trbm_pkg.sv
// Package for the table row block mover: field widths, operation and register codes,
// and the types shared by the controller, the store and the top level.
// Depends on nothing.
`default_nettype none

package trbm_pkg;

  localparam int ROW_W      = 9;
  localparam int COL_W      = 5;
  localparam int DATA_W     = 32;
  localparam int OP_W       = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;

  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_MOVE  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 1'd1;

  localparam logic [ROW_W-1:0] ROW_COUNT_RST = 9'd256;
  localparam logic [COL_W-1:0] COL_COUNT_RST = 5'd16;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_WRITE,
    KIND_READ,
    KIND_MOVE
  } cmd_kind_t;

  typedef enum logic [1:0] {
    WSRC_VALUE,
    WSRC_TAB,
    WSRC_BLK
  } wsrc_t;

  typedef enum logic [1:0] {
    PH_SAVE,
    PH_SHIFT,
    PH_RESTORE
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_WAIT,
    ST_COPY,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic             status;
    logic [ROW_W-1:0] first_row;
    logic [ROW_W-1:0] last_row;
    logic [ROW_W-1:0] dest_row;
  } cmd_t;

  typedef struct packed {
    logic  tab_re;
    logic  tab_we;
    logic  blk_re;
    logic  blk_we;
    wsrc_t wsrc;
  } mem_ctl_t;

endpackage

`default_nettype wire

>>> rtl/trbm_store.sv
// Table memory and block scratch memory, each with one write and one registered read port.
// Depends on trbm_pkg for the memory control struct and data width.
`default_nettype none

module trbm_store #(
  parameter int MAX_ROWS = 256,
  parameter int MAX_COLS = 16,
  localparam int DEPTH = MAX_ROWS * MAX_COLS,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int BW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
  input  wire logic                         clk,
  input  wire trbm_pkg::mem_ctl_t           mctl,
  input  wire logic [AW-1:0]                tab_raddr,
  input  wire logic [AW-1:0]                tab_waddr,
  input  wire logic [BW-1:0]                blk_raddr,
  input  wire logic [BW-1:0]                blk_waddr,
  input  wire logic [trbm_pkg::DATA_W-1:0]  value,
  output logic      [trbm_pkg::DATA_W-1:0]  tab_rdata
);

  logic [trbm_pkg::DATA_W-1:0] tab_mem [DEPTH];
  logic [trbm_pkg::DATA_W-1:0] blk_mem [MAX_ROWS];
  logic [trbm_pkg::DATA_W-1:0] tab_rdata_r;
  logic [trbm_pkg::DATA_W-1:0] blk_rdata_r;
  logic [trbm_pkg::DATA_W-1:0] tab_wdata;

  always_comb begin
    case (mctl.wsrc)
      trbm_pkg::WSRC_VALUE: tab_wdata = value;
      trbm_pkg::WSRC_BLK:   tab_wdata = blk_rdata_r;
      default:              tab_wdata = tab_rdata_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mctl.tab_we) begin
      tab_mem[tab_waddr] <= tab_wdata;
    end
    if (mctl.tab_re) begin
      tab_rdata_r <= tab_mem[tab_raddr];
    end
  end

  // The scratch memory only ever receives words just read from the table.
  always_ff @(posedge clk) begin
    if (mctl.blk_we) begin
      blk_mem[blk_waddr] <= tab_rdata_r;
    end
    if (mctl.blk_re) begin
      blk_rdata_r <= blk_mem[blk_raddr];
    end
  end

  assign tab_rdata = tab_rdata_r;

endmodule

`default_nettype wire

>>> rtl/trbm_ctrl.sv
// Sequencer for cell accesses and row block moves: issues reads, pipelined write-backs
// and the per-column save, shift and restore passes. Depends on trbm_pkg.
`default_nettype none

module trbm_ctrl #(
  parameter int MAX_ROWS = 256,
  parameter int MAX_COLS = 16,
  localparam int DEPTH = MAX_ROWS * MAX_COLS,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int BW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire trbm_pkg::cmd_t               cmd,
  input  wire logic [AW-1:0]                cell_idx,
  input  wire logic [trbm_pkg::ROW_W-1:0]   row_count,
  input  wire logic [trbm_pkg::COL_W-1:0]   col_count,
  input  wire logic [trbm_pkg::DATA_W-1:0]  tab_rdata,
  input  wire logic                         slot_free,
  output logic                              idle,
  output logic                              done,
  output logic                              res_status,
  output logic      [trbm_pkg::DATA_W-1:0]  res_value,
  output trbm_pkg::mem_ctl_t                mctl,
  output logic      [AW-1:0]                tab_raddr,
  output logic      [AW-1:0]                tab_waddr,
  output logic      [BW-1:0]                blk_raddr,
  output logic      [BW-1:0]                blk_waddr
);

  trbm_pkg::state_t state_r, state_nxt;
  trbm_pkg::phase_t phase_r;

  logic [trbm_pkg::ROW_W-1:0] cnt_r, src_r, dst_r, wp_dst_r;
  logic [trbm_pkg::ROW_W-1:0] first0_r, nline_r, mid_r, newdst_r, shift_src_r, shift_dst_r;
  logic                       desc_r, up_r, wp_valid_r;
  logic [trbm_pkg::COL_W-1:0] col_r;
  logic [AW-1:0]              base_r;
  logic                       res_status_r;
  logic [trbm_pkg::DATA_W-1:0] res_value_r;

  logic [trbm_pkg::ROW_W-1:0] mv_nline, mv_mid, mv_newdst, mv_shift_src, mv_shift_dst;
  logic                       mv_up, last_col;

  // Block geometry, worked out once when a move is taken.
  always_comb begin
    mv_up        = cmd.dest_row > cmd.last_row;
    mv_nline     = cmd.last_row - cmd.first_row + 9'd1;
    mv_mid       = mv_up ? (cmd.dest_row - cmd.last_row)
                         : (cmd.first_row - cmd.dest_row - 9'd1);
    mv_newdst    = mv_up ? (cmd.dest_row - mv_nline) : cmd.dest_row;
    mv_shift_src = mv_up ? cmd.last_row : (cmd.first_row - 9'd2);
    mv_shift_dst = mv_up ? (cmd.first_row - 9'd1) : (cmd.last_row - 9'd1);
  end

  assign last_col = (col_r == (col_count - 5'd1));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      trbm_pkg::ST_IDLE: begin
        if (start) begin
          case (cmd.kind)
            trbm_pkg::KIND_READ: state_nxt = trbm_pkg::ST_RD_WAIT;
            trbm_pkg::KIND_MOVE: state_nxt = trbm_pkg::ST_COPY;
            default:             state_nxt = trbm_pkg::ST_FINISH;
          endcase
        end
      end
      trbm_pkg::ST_RD_WAIT: state_nxt = trbm_pkg::ST_FINISH;
      trbm_pkg::ST_COPY: begin
        if (cnt_r == 9'd1) begin
          state_nxt = trbm_pkg::ST_DRAIN;
        end
      end
      trbm_pkg::ST_DRAIN: begin
        if (phase_r == trbm_pkg::PH_RESTORE && last_col) begin
          state_nxt = trbm_pkg::ST_FINISH;
        end else begin
          state_nxt = trbm_pkg::ST_COPY;
        end
      end
      trbm_pkg::ST_FINISH: begin
        if (slot_free) begin
          state_nxt = trbm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = trbm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= trbm_pkg::ST_IDLE;
      phase_r    <= trbm_pkg::PH_SAVE;
      cnt_r      <= '0;
      col_r      <= '0;
      wp_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      wp_valid_r <= (state_r == trbm_pkg::ST_COPY);
      case (state_r)
        trbm_pkg::ST_IDLE: begin
          if (start && cmd.kind == trbm_pkg::KIND_MOVE) begin
            phase_r <= trbm_pkg::PH_SAVE;
            cnt_r   <= mv_nline;
            col_r   <= '0;
          end
        end
        trbm_pkg::ST_COPY: cnt_r <= cnt_r - 9'd1;
        trbm_pkg::ST_DRAIN: begin
          case (phase_r)
            trbm_pkg::PH_SAVE: begin
              phase_r <= trbm_pkg::PH_SHIFT;
              cnt_r   <= mid_r;
            end
            trbm_pkg::PH_SHIFT: begin
              phase_r <= trbm_pkg::PH_RESTORE;
              cnt_r   <= nline_r;
            end
            default: begin
              phase_r <= trbm_pkg::PH_SAVE;
              cnt_r   <= nline_r;
              col_r   <= col_r + 5'd1;
            end
          endcase
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    wp_dst_r <= dst_r;
    case (state_r)
      trbm_pkg::ST_IDLE: begin
        if (start) begin
          res_status_r <= cmd.status;
          res_value_r  <= '0;
          first0_r     <= cmd.first_row - 9'd1;
          nline_r      <= mv_nline;
          mid_r        <= mv_mid;
          newdst_r     <= mv_newdst;
          shift_src_r  <= mv_shift_src;
          shift_dst_r  <= mv_shift_dst;
          up_r         <= mv_up;
          src_r        <= cmd.first_row - 9'd1;
          dst_r        <= '0;
          desc_r       <= 1'b0;
          base_r       <= '0;
        end
      end
      trbm_pkg::ST_RD_WAIT: res_value_r <= tab_rdata;
      trbm_pkg::ST_COPY: begin
        src_r <= desc_r ? (src_r - 9'd1) : (src_r + 9'd1);
        dst_r <= desc_r ? (dst_r - 9'd1) : (dst_r + 9'd1);
      end
      trbm_pkg::ST_DRAIN: begin
        case (phase_r)
          trbm_pkg::PH_SAVE: begin
            src_r  <= shift_src_r;
            dst_r  <= shift_dst_r;
            desc_r <= !up_r;
          end
          trbm_pkg::PH_SHIFT: begin
            src_r  <= '0;
            dst_r  <= newdst_r;
            desc_r <= 1'b0;
          end
          default: begin
            src_r  <= first0_r;
            dst_r  <= '0;
            desc_r <= 1'b0;
            base_r <= base_r + AW'(row_count);
          end
        endcase
      end
      default: ;
    endcase
  end

  always_comb begin
    mctl      = '{tab_re: 1'b0, tab_we: 1'b0, blk_re: 1'b0, blk_we: 1'b0,
                  wsrc: trbm_pkg::WSRC_TAB};
    tab_raddr = base_r + AW'(src_r);
    tab_waddr = base_r + AW'(wp_dst_r);
    blk_raddr = BW'(src_r);
    blk_waddr = BW'(wp_dst_r);
    unique case (state_r)
      trbm_pkg::ST_IDLE: begin
        if (start && cmd.kind == trbm_pkg::KIND_WRITE) begin
          mctl.tab_we = 1'b1;
          mctl.wsrc   = trbm_pkg::WSRC_VALUE;
          tab_waddr   = cell_idx;
        end
        if (start && cmd.kind == trbm_pkg::KIND_READ) begin
          mctl.tab_re = 1'b1;
          tab_raddr   = cell_idx;
        end
      end
      trbm_pkg::ST_COPY: begin
        if (phase_r == trbm_pkg::PH_RESTORE) begin
          mctl.blk_re = 1'b1;
        end else begin
          mctl.tab_re = 1'b1;
        end
      end
      default: ;
    endcase
    // Write-back of the word read in the previous cycle.
    if (wp_valid_r) begin
      case (phase_r)
        trbm_pkg::PH_SAVE:  mctl.blk_we = 1'b1;
        trbm_pkg::PH_SHIFT: mctl.tab_we = 1'b1;
        default: begin
          mctl.tab_we = 1'b1;
          mctl.wsrc   = trbm_pkg::WSRC_BLK;
        end
      endcase
    end
  end

  assign idle       = (state_r == trbm_pkg::ST_IDLE);
  assign done       = (state_r == trbm_pkg::ST_FINISH) && slot_free;
  assign res_status = res_status_r;
  assign res_value  = res_value_r;

endmodule

`default_nettype wire

>>> rtl/table_row_block_move_top.sv
// Top level of the table row block mover: configuration registers, item decode and checks,
// result register. Depends on trbm_pkg, trbm_store and trbm_ctrl.
`default_nettype none

//  Channel   Ports                                             Direction   Handshake
//  input     in_operation .. in_value                          in          in_valid / in_stall
//  result    out_read_value, out_status                        out         out_valid / out_stall
//  config    cfg_we, cfg_index, cfg_data                       in          cfg_we only
//
// A write, a rejected item or a move that changes nothing goes from acceptance straight to
// the finish state; a read first waits for its registered table word. In a move, every
// affected word passes through the single read port and single write port of the table
// memory, first into the scratch memory, then the rows between, then the block back.
// Reset is synchronous and active low; the memories are not cleared, so the user must write
// each word before reading it: the block itself does not enforce this. A new item is taken
// whenever the sequencer is idle, even while the previous result still waits in the output
// register; only the final hand-over of a result waits for that register to free.

module table_row_block_move_top #(
  parameter int MAX_ROWS = 256,
  parameter int MAX_COLS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [trbm_pkg::OP_W-1:0]         in_operation,
  input  wire logic [trbm_pkg::ROW_W-1:0]        in_first_row,
  input  wire logic [trbm_pkg::ROW_W-1:0]        in_last_row,
  input  wire logic [trbm_pkg::ROW_W-1:0]        in_dest_row,
  input  wire logic [trbm_pkg::COL_W-1:0]        in_column,
  input  wire logic signed [trbm_pkg::DATA_W-1:0] in_value,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [trbm_pkg::DATA_W-1:0]     out_read_value,
  output logic                                   out_status,
  input  wire logic                              cfg_we,
  input  wire logic [trbm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [trbm_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int BW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  logic [trbm_pkg::ROW_W-1:0] row_count_r;
  logic [trbm_pkg::COL_W-1:0] col_count_r;

  logic                        out_valid_r, out_status_r;
  logic [trbm_pkg::DATA_W-1:0] out_value_r;

  logic                        idle, start, done, slot_free, res_status;
  logic [trbm_pkg::DATA_W-1:0] res_value, tab_rdata;
  logic                        geom_ok, cell_ok, block_ok, move_does_work;
  logic [14:0]                 cell_lin;
  logic [AW-1:0]               cell_idx;
  trbm_pkg::cmd_t              cmd;
  trbm_pkg::mem_ctl_t          mctl;
  logic [AW-1:0]               tab_raddr, tab_waddr;
  logic [BW-1:0]               blk_raddr, blk_waddr;

  // Register writes only change the geometry (row stride and column count); stored words stay where they are.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= trbm_pkg::ROW_COUNT_RST;
      col_count_r <= trbm_pkg::COL_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        trbm_pkg::REG_ROW_COUNT: row_count_r <= cfg_data;
        trbm_pkg::REG_COL_COUNT: col_count_r <= cfg_data[trbm_pkg::COL_W-1:0];
        default: ;
      endcase
    end
  end

  // Geometry must fit the memories, or every item is turned away.
  assign geom_ok = (row_count_r != '0) && (32'(row_count_r) <= 32'(MAX_ROWS)) &&
                   (col_count_r != '0) && (32'(col_count_r) <= 32'(MAX_COLS));

  assign cell_ok = (in_first_row != '0) && (in_first_row <= row_count_r) &&
                   (in_column != '0) && (in_column <= col_count_r);

  assign block_ok = (in_first_row != '0) && (in_first_row <= in_last_row) &&
                    (in_last_row <= row_count_r) && (in_dest_row <= row_count_r);

  // A destination inside or just above the block leaves the table as it is.
  assign move_does_work = (in_dest_row > in_last_row) ||
                          (({1'b0, in_dest_row} + 10'd1) < {1'b0, in_first_row});

  // Column-major cell address; only used when the cell check passes.
  assign cell_lin = 15'(row_count_r) * 15'(in_column - 5'd1) + 15'(in_first_row - 9'd1);
  assign cell_idx = AW'(cell_lin);

  always_comb begin
    cmd.kind      = trbm_pkg::KIND_NONE;
    cmd.status    = 1'b1;
    cmd.first_row = in_first_row;
    cmd.last_row  = in_last_row;
    cmd.dest_row  = in_dest_row;
    if (geom_ok) begin
      unique case (in_operation)
        trbm_pkg::OP_WRITE: begin
          if (cell_ok) begin
            cmd.kind   = trbm_pkg::KIND_WRITE;
            cmd.status = 1'b0;
          end
        end
        trbm_pkg::OP_READ: begin
          if (cell_ok) begin
            cmd.kind   = trbm_pkg::KIND_READ;
            cmd.status = 1'b0;
          end
        end
        trbm_pkg::OP_MOVE: begin
          if (block_ok) begin
            cmd.status = 1'b0;
            if (move_does_work) begin
              cmd.kind = trbm_pkg::KIND_MOVE;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign in_stall  = !idle;
  assign start     = in_valid && idle;
  assign slot_free = !out_valid_r || !out_stall;

  trbm_ctrl #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .cmd        (cmd),
    .cell_idx   (cell_idx),
    .row_count  (row_count_r),
    .col_count  (col_count_r),
    .tab_rdata  (tab_rdata),
    .slot_free  (slot_free),
    .idle       (idle),
    .done       (done),
    .res_status (res_status),
    .res_value  (res_value),
    .mctl       (mctl),
    .tab_raddr  (tab_raddr),
    .tab_waddr  (tab_waddr),
    .blk_raddr  (blk_raddr),
    .blk_waddr  (blk_waddr)
  );

  trbm_store #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_store (
    .clk       (clk),
    .mctl      (mctl),
    .tab_raddr (tab_raddr),
    .tab_waddr (tab_waddr),
    .blk_raddr (blk_raddr),
    .blk_waddr (blk_waddr),
    .value     (in_value),
    .tab_rdata (tab_rdata)
  );

  // Result register: the sequencer hands over a result only when this slot is free.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_status_r <= res_status;
      out_value_r  <= res_value;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_read_value = out_value_r;

endmodule

`default_nettype wire

>>> verif/table_row_block_move_top_tb.sv
// Self-checking testbench for table_row_block_move_top: cell writes, cell reads and row block
// moves, checked against a behavioural copy of the table. Depends on trbm_pkg and the RTL top.
`default_nettype none

module table_row_block_move_top_tb;
  import trbm_pkg::*;

  // Geometry limits of the instance under test; the block uses its defaults.
  localparam int MAX_ROWS    = 256;
  localparam int MAX_COLS    = 16;
  localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;

  // Operation code 3 is not defined by the block and must be rejected.
  localparam logic [OP_W-1:0] OP_UNKNOWN = 2'd3;

  // Bounds for the idle draws on both sides, for the long hold-off on the result side and
  // for the watchdog limit of the whole run, whose slowest correct part is the moves at the
  // largest geometry.
  localparam int MAX_GAP     = 13;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 2_000_000;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    logic                     status;
  } cell_result_t;

  logic                     clk   = 1'b0;
  logic                     rst_n = 1'b0;

  logic                     in_valid     = 1'b0;
  logic                     in_stall;
  logic [OP_W-1:0]          in_operation = OP_WRITE;
  logic [ROW_W-1:0]         in_first_row = '0;
  logic [ROW_W-1:0]         in_last_row  = '0;
  logic [ROW_W-1:0]         in_dest_row  = '0;
  logic [COL_W-1:0]         in_column    = '0;
  logic signed [DATA_W-1:0] in_value     = '0;

  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [DATA_W-1:0] out_read_value;
  logic                     out_status;

  logic                     cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = REG_ROW_COUNT;
  logic [CFG_DATA_W-1:0]    cfg_data  = '0;

  table_row_block_move_top u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_first_row   (in_first_row),
    .in_last_row    (in_last_row),
    .in_dest_row    (in_dest_row),
    .in_column      (in_column),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_read_value (out_read_value),
    .out_status     (out_status),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // The testbench's own copy of the table, column-major with the current row stride, and a
  // flag per word that records whether it holds a defined word. A move carries the flags
  // along with the words. A read is only sent once its cell holds a defined word, since the
  // store starts undefined.
  logic [DATA_W-1:0] tab_model [0:STORE_DEPTH-1];
  bit                cell_written [0:STORE_DEPTH-1];
  logic [ROW_W-1:0]  rows_cfg = ROW_COUNT_RST;
  logic [COL_W-1:0]  cols_cfg = COL_COUNT_RST;

  // Results that the table is due to return, oldest first.
  cell_result_t pending_results [$];

  int  gap_max      = MAX_GAP;
  bit  hold_request = 1'b0;
  int  cycle_count  = 0;
  int  failures     = 0;
  int  items_sent   = 0;
  int  moves_done   = 0;
  int  rejects      = 0;
  int  reg_writes   = 0;
  int  results_seen = 0;
  int  holds_done   = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Run stopped at the cycle limit with %0d results outstanding.",
               pending_results.size());
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Behavioural table
  // ---------------------------------------------------------------------------------------

  function automatic bit geometry_ok();
    return rows_cfg >= 1 && rows_cfg <= MAX_ROWS && cols_cfg >= 1 && cols_cfg <= MAX_COLS;
  endfunction

  function automatic bit cell_in_range(input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col);
    return row >= 1 && row <= rows_cfg && col >= 1 && col <= cols_cfg;
  endfunction

  function automatic bit block_in_range(input logic [ROW_W-1:0] first,
                                        input logic [ROW_W-1:0] last,
                                        input logic [ROW_W-1:0] dest);
    return first >= 1 && first <= last && last <= rows_cfg && dest <= rows_cfg;
  endfunction

  function automatic int cell_index(input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col);
    int r;
    int c;
    r = int'(row);
    c = int'(col);
    return int'(rows_cfg) * (c - 1) + (r - 1);
  endfunction

  // Rebuilds every column in its new row order. Each new position p (1-based) takes the row
  // that the block placement sends to it; rows outside the affected span stay put.
  function automatic void rotate_rows(input int first, input int last, input int dest);
    logic [DATA_W-1:0] column_copy [0:MAX_ROWS-1];
    bit                mark_copy [0:MAX_ROWS-1];
    int n;
    int c;
    int p;
    int src;
    int base;
    n = last - first + 1;
    // A block dropped just before itself or anywhere inside itself goes nowhere.
    if (dest >= first - 1 && dest <= last) return;
    for (c = 0; c < cols_cfg; c++) begin
      base = int'(rows_cfg) * c;
      for (p = 0; p < rows_cfg; p++) begin
        column_copy[p] = tab_model[base + p];
        mark_copy[p]   = cell_written[base + p];
      end
      for (p = 1; p <= rows_cfg; p++) begin
        src = p;
        if (dest > last) begin
          if (p >= first && p <= dest - n) src = p + n;
          else if (p > dest - n && p <= dest) src = p - dest + n + first - 1;
        end else begin
          if (p > dest && p <= dest + n) src = first + p - dest - 1;
          else if (p > dest + n && p <= last) src = p - n;
        end
        tab_model[base + p - 1]    = column_copy[src - 1];
        cell_written[base + p - 1] = mark_copy[src - 1];
      end
    end
  endfunction

  // Applies one accepted item to the table copy and returns the result it must produce.
  function automatic cell_result_t table_apply(input logic [OP_W-1:0] op,
                                               input logic [ROW_W-1:0] first,
                                               input logic [ROW_W-1:0] last,
                                               input logic [ROW_W-1:0] dest,
                                               input logic [COL_W-1:0] col,
                                               input logic [DATA_W-1:0] val);
    cell_result_t res;
    int idx;
    res.read_value = '0;
    res.status     = 1'b1;
    if (geometry_ok()) begin
      if ((op == OP_WRITE || op == OP_READ) && cell_in_range(first, col)) begin
        idx = cell_index(first, col);
        if (op == OP_WRITE) begin
          tab_model[idx]    = val;
          cell_written[idx] = 1'b1;
        end else begin
          res.read_value = tab_model[idx];
        end
        res.status = 1'b0;
      end else if (op == OP_MOVE && block_in_range(first, last, dest)) begin
        rotate_rows(int'(first), int'(last), int'(dest));
        res.status = 1'b0;
      end
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------------------

  function automatic int draw_gap();
    return $urandom_range(0, gap_max);
  endfunction

  // Offers one item after an idle gap and returns at the edge that accepts it. The valid is
  // left high on return, so the caller either sends the next item in the same step or lowers
  // it; the gap path and the drain task are the only places that lower it.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [ROW_W-1:0] first,
                           input logic [ROW_W-1:0] last, input logic [ROW_W-1:0] dest,
                           input logic [COL_W-1:0] col, input logic [DATA_W-1:0] val,
                           input int gap);
    cell_result_t res;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_operation <= op;
    in_first_row <= first;
    in_last_row  <= last;
    in_dest_row  <= dest;
    in_column    <= col;
    in_value     <= val;
    in_valid     <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    res = table_apply(op, first, last, dest, col, val);
    pending_results.push_back(res);
    items_sent++;
    if (res.status) rejects++;
    else if (op == OP_MOVE) moves_done++;
  endtask

  // Sends an item, first writing the cell that a read would return while that cell still
  // holds no defined word.
  task automatic issue_item(input logic [OP_W-1:0] op, input logic [ROW_W-1:0] first,
                            input logic [ROW_W-1:0] last, input logic [ROW_W-1:0] dest,
                            input logic [COL_W-1:0] col, input logic [DATA_W-1:0] val);
    if (geometry_ok() && op == OP_READ && cell_in_range(first, col)) begin
      if (!cell_written[cell_index(first, col)])
        send_item(OP_WRITE, first, '0, '0, col, $urandom, 0);
    end
    send_item(op, first, last, dest, col, val, draw_gap());
  endtask

  // Drops the valid and waits until every outstanding result has been taken, then lets the
  // sequencer settle before anything touches the registers.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  // One register write. The leading edge keeps a lowered enable and a raised one apart when
  // two writes follow each other.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_ROW_COUNT) rows_cfg = data[ROW_W-1:0];
    else cols_cfg = data[COL_W-1:0];
    reg_writes++;
  endtask

  // The column count only uses the low bits of the data word; the upper ones are random.
  task automatic set_geometry(input logic [ROW_W-1:0] rows, input logic [COL_W-1:0] cols);
    logic [31:0]                 pad_bits;
    logic [CFG_DATA_W-COL_W-1:0] pad;
    pad_bits = $urandom;
    pad      = pad_bits[CFG_DATA_W-COL_W-1:0];
    wait_idle();
    write_reg(REG_ROW_COUNT, rows);
    write_reg(REG_COL_COUNT, {pad, cols});
  endtask

  // ---------------------------------------------------------------------------------------
  // Result side: stall draws and checking
  // ---------------------------------------------------------------------------------------

  // For every result the receiver stalls for a drawn number of cycles, then takes it. A hold
  // request from a test replaces one draw with a long hold-off.
  initial begin
    int wait_n;
    @(posedge rst_n);
    forever begin
      wait_n = draw_gap();
      if (hold_request) begin
        hold_request = 1'b0;
        wait_n = HOLD_CYCLES;
        holds_done++;
      end
      if (wait_n > 0) begin
        out_stall <= 1'b1;
        repeat (wait_n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic note_mismatch(input string what, input logic [DATA_W-1:0] want_v,
                               input logic [DATA_W-1:0] got_v);
    failures++;
    if (failures <= 10)
      $display("Mismatch at cycle %0d: %s, expected %h, got %h", cycle_count, what, want_v,
               got_v);
  endtask

  always @(posedge clk) begin
    cell_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        note_mismatch("result with nothing outstanding", '0, out_read_value);
      end else begin
        want = pending_results.pop_front();
        if (out_read_value !== want.read_value)
          note_mismatch("read_value", want.read_value, out_read_value);
        if (out_status !== want.status)
          note_mismatch("status", {31'd0, want.status}, {31'd0, out_status});
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------------------

  // Cell access at the reset geometry: corner cells with extreme words, then every way of
  // addressing a cell outside the table, and the undefined operation.
  task automatic test_cell_access();
    issue_item(OP_WRITE, 9'd1, '0, '0, 5'd1, 32'h8000_0000);
    issue_item(OP_WRITE, 9'd256, '0, '0, 5'd16, 32'h7FFF_FFFF);
    issue_item(OP_WRITE, 9'd256, 9'h1FF, 9'h1FF, 5'd1, 32'hFFFF_FFFF);
    issue_item(OP_WRITE, 9'd1, '0, '0, 5'd16, 32'h0000_0000);
    issue_item(OP_READ, 9'd1, '0, '0, 5'd1, 32'hFFFF_FFFF);
    issue_item(OP_READ, 9'd256, '0, '0, 5'd16, '0);
    issue_item(OP_READ, 9'd256, '0, '0, 5'd1, '0);
    issue_item(OP_WRITE, 9'd0, '0, '0, 5'd1, 32'h1234_5678);
    issue_item(OP_READ, 9'd257, '0, '0, 5'd1, '0);
    issue_item(OP_READ, 9'h1FF, '0, '0, 5'd2, '0);
    issue_item(OP_WRITE, 9'd5, '0, '0, 5'd0, 32'hDEAD_BEEF);
    issue_item(OP_READ, 9'd5, '0, '0, 5'd17, '0);
    issue_item(OP_WRITE, 9'd5, '0, '0, 5'h1F, 32'hCAFE_F00D);
    issue_item(OP_UNKNOWN, 9'd1, 9'd1, 9'd0, 5'd1, 32'h5555_AAAA);
  endtask

  // Moves at the full geometry. The first one is a no-op that spans the whole table; the
  // next two carry the corner words to the far end of each column and back again.
  task automatic test_move_cases();
    issue_item(OP_MOVE, 9'd1, 9'd256, 9'd0, 5'd1, '0);
    issue_item(OP_MOVE, 9'd1, 9'd1, 9'd256, 5'd31, '0);
    issue_item(OP_READ, 9'd256, '0, '0, 5'd1, '0);
    issue_item(OP_MOVE, 9'd256, 9'd256, 9'd0, 5'd0, 32'hFFFF_FFFF);
    issue_item(OP_MOVE, 9'd10, 9'd20, 9'd5, 5'd3, '0);
    issue_item(OP_MOVE, 9'd10, 9'd20, 9'd30, 5'd3, '0);
    issue_item(OP_MOVE, 9'd5, 9'd9, 9'd4, 5'd3, '0);
    issue_item(OP_MOVE, 9'd5, 9'd9, 9'd9, 5'd3, '0);
    issue_item(OP_MOVE, 9'd0, 9'd3, 9'd7, 5'd1, '0);
    issue_item(OP_MOVE, 9'd30, 9'd20, 9'd0, 5'd1, '0);
    issue_item(OP_MOVE, 9'd2, 9'd257, 9'd0, 5'd1, '0);
    issue_item(OP_MOVE, 9'd2, 9'd4, 9'h1FF, 5'd1, '0);
    issue_item(OP_READ, 9'd1, '0, '0, 5'd16, '0);
  endtask

  // Register extremes: geometries that reject everything, then the smallest legal table.
  task automatic test_bad_geometry();
    set_geometry(9'd0, 5'd16);
    issue_item(OP_WRITE, 9'd1, '0, '0, 5'd1, 32'h0BAD_0001);
    set_geometry(9'd257, 5'd16);
    issue_item(OP_READ, 9'd1, '0, '0, 5'd1, '0);
    set_geometry(9'h1FF, 5'd0);
    issue_item(OP_MOVE, 9'd1, 9'd2, 9'd5, 5'd1, '0);
    set_geometry(9'd256, 5'd17);
    issue_item(OP_READ, 9'd1, '0, '0, 5'd1, '0);
    set_geometry(9'd256, 5'h1F);
    issue_item(OP_WRITE, 9'd2, '0, '0, 5'd2, 32'h0BAD_0002);
    set_geometry(9'd1, 5'd1);
    issue_item(OP_WRITE, 9'd1, '0, '0, 5'd1, 32'hA5A5_5A5A);
    issue_item(OP_MOVE, 9'd1, 9'd1, 9'd0, 5'd1, '0);
    issue_item(OP_MOVE, 9'd1, 9'd1, 9'd1, 5'd1, '0);
    issue_item(OP_MOVE, 9'd1, 9'd1, 9'd2, 5'd1, '0);
    issue_item(OP_READ, 9'd1, '0, '0, 5'd2, '0);
    issue_item(OP_READ, 9'd1, '0, '0, 5'd1, '0);
  endtask

  // Random traffic over several geometries. Most items are legal writes, reads and moves
  // with random content; the rest are random bit patterns in every field. One phase uses a
  // large table with short blocks, and one runs with no idling on either side.
  task automatic test_random_traffic();
    logic [31:0]      noise;
    logic [ROW_W-1:0] rows;
    logic [COL_W-1:0] cols;
    logic [ROW_W-1:0] first;
    logic [ROW_W-1:0] last;
    logic [ROW_W-1:0] dest;
    logic [COL_W-1:0] col;
    logic [OP_W-1:0]  op;
    int phase;
    int n;
    int count;
    int pick;
    int reach;
    for (phase = 0; phase < 6; phase++) begin
      if (phase == 2) begin
        rows  = ROW_W'($urandom_range(128, 256));
        cols  = COL_W'($urandom_range(9, 16));
        count = 6;
        reach = 15;
      end else begin
        rows  = ROW_W'($urandom_range(1, 24));
        cols  = COL_W'($urandom_range(1, 5));
        count = 10;
        reach = 24;
      end
      set_geometry(rows, cols);
      gap_max = (phase == 4) ? 0 : MAX_GAP;
      for (n = 0; n < count; n++) begin
        pick  = $urandom_range(0, 99);
        noise = $urandom;
        first = ROW_W'($urandom_range(1, rows));
        last  = noise[ROW_W-1:0];
        dest  = noise[2*ROW_W-1:ROW_W];
        col   = COL_W'($urandom_range(1, cols));
        if (pick < 35) begin
          op = OP_WRITE;
        end else if (pick < 60) begin
          op = OP_READ;
        end else if (pick < 85) begin
          op   = OP_MOVE;
          last = ROW_W'($urandom_range(first,
                                       (first + reach > rows) ? rows : first + reach));
          dest = ROW_W'($urandom_range(0, rows));
          col  = noise[31:27];
        end else begin
          op    = noise[31:30];
          first = noise[ROW_W-1:0];
          last  = noise[2*ROW_W-1:ROW_W];
          dest  = noise[3*ROW_W-1:2*ROW_W];
          col   = noise[3*ROW_W+COL_W-1:3*ROW_W];
        end
        issue_item(op, first, last, dest, col, $urandom);
      end
    end
    gap_max = MAX_GAP;
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering items back
  // to back, so the output register fills, the sequencer fills behind it and the input
  // stalls until the hold-off ends. Every read returns the cell written just before it.
  task automatic test_backpressure();
    int n;
    int k;
    set_geometry(9'd8, 5'd2);
    hold_request = 1'b1;
    for (n = 0; n < 12; n++) begin
      k = (n % 3 == 2) ? n - 1 : n;
      send_item((n % 3 == 2) ? OP_READ : OP_WRITE, ROW_W'((k % 8) + 1), '0, '0,
                COL_W'((k % 2) + 1), $urandom, 0);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_cell_access();
    test_move_cases();
    test_bad_geometry();
    test_random_traffic();
    test_backpressure();
    wait_idle();
    $display("Sent %0d items (%0d moves applied, %0d rejected) over %0d register writes,",
             items_sent, moves_done, rejects, reg_writes);
    $display("checked %0d results with %0d long hold-off(s); %0d mismatch(es).",
             results_seen, holds_done, failures);
    if (failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
